[hw/rtl/gbs_pkg.sv]
// Shared types, widths and register codes for the best-split search core.
// Used by every module of the core but gbs_ram; it depends on nothing else.
package gbs_pkg;

  // Field and datapath widths.
  localparam int SUM_W        = 48;  // column sums of gradients and hessians
  localparam int SQ_W         = 96;  // squared gradient sum, also divider dividend
  localparam int DEN_W        = 50;  // doubled hessian sum plus lambda
  localparam int CNT_W        = 17;  // sample count, holds the largest column size
  localparam int LAMBDA_W     = 31;
  localparam int MIN_SIDE_W   = 11;
  localparam int CFG_W        = 31;
  localparam int GAIN_W       = 64;
  localparam int WEIGHT_W     = 32;

  localparam int DEF_MAX_SAMPLES = 1024;

  localparam logic [LAMBDA_W-1:0]   LAMBDA_RESET   = 31'd65536;
  localparam logic [MIN_SIDE_W-1:0] MIN_SIDE_RESET = 11'd2;

  localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};

  // Configuration register indexes.
  localparam logic CFG_IDX_LAMBDA   = 1'b0;
  localparam logic CFG_IDX_MIN_SIDE = 1'b1;

  // One input beat.
  typedef struct packed {
    logic signed [31:0] feature_value;
    logic signed [31:0] gradient;
    logic [30:0]        hessian;
    logic [7:0]         feature_id;
    logic               column_end;
    logic               node_end;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic               split_found;
    logic [7:0]         split_feature;
    logic signed [31:0] best_value;
    logic signed [63:0] split_gain;
    logic signed [31:0] left_weight;
    logic signed [31:0] right_weight;
    logic signed [31:0] leaf_weight;
  } result_t;

  // One stored sample.
  typedef struct packed {
    logic [31:0] value;
    logic [31:0] grad;
    logic [30:0] hess;
  } sample_t;

  // Finished column handed from the loader to the scanner.
  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] total_grad;
    logic [SUM_W-1:0]        total_hess;
    logic [7:0]              feature;
    logic                    node_end;
  } col_desc_t;

endpackage

[hw/rtl/gbs_ram.sv]
// Generic single-write, single-read memory with registered read data.
// Stand-alone; no package needed.
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/gbs_front.sv]
// Loader: accepts sample beats, writes them to the sample memory and keeps column sums.
// Hands each finished column to the scanner through a one-entry queue. Uses gbs_pkg.
module gbs_front #(
  parameter int MAX_SAMPLES = gbs_pkg::DEF_MAX_SAMPLES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  gbs_pkg::item_t                 in_item,
  input  logic                           back_busy,
  input  logic                           desc_ack,
  output logic                           busy,
  output logic                           ram_we,
  output logic [$clog2(MAX_SAMPLES)-1:0] ram_waddr,
  output gbs_pkg::sample_t               ram_wdata,
  output logic                           desc_valid,
  output gbs_pkg::col_desc_t             desc
);

  localparam int AW = $clog2(MAX_SAMPLES);

  logic [gbs_pkg::CNT_W-1:0]        count_r;
  logic signed [gbs_pkg::SUM_W-1:0] tg_r;
  logic [gbs_pkg::SUM_W-1:0]        th_r;
  logic                             desc_valid_r;
  gbs_pkg::col_desc_t               desc_r;

  logic                             accept;
  logic                             store;
  logic [gbs_pkg::CNT_W-1:0]        count_nxt;
  logic signed [gbs_pkg::SUM_W-1:0] tg_nxt;
  logic [gbs_pkg::SUM_W-1:0]        th_nxt;

  // The scanner reads the memory, so no beat is taken while a column is pending or being scanned.
  assign busy   = desc_valid_r | back_busy;
  assign accept = start & ~busy;
  assign store  = count_r < gbs_pkg::CNT_W'(MAX_SAMPLES);

  // Samples beyond the memory depth are dropped from storage and sums.
  always_comb begin
    count_nxt = count_r;
    tg_nxt    = tg_r;
    th_nxt    = th_r;
    if (store) begin
      count_nxt = count_r + gbs_pkg::CNT_W'(1);
      tg_nxt    = tg_r + {{(gbs_pkg::SUM_W-32){in_item.gradient[31]}}, in_item.gradient};
      th_nxt    = th_r + {{(gbs_pkg::SUM_W-31){1'b0}}, in_item.hessian};
    end
  end

  assign ram_we              = accept & store;
  assign ram_waddr           = count_r[AW-1:0];
  assign ram_wdata.value     = in_item.feature_value;
  assign ram_wdata.grad      = in_item.gradient;
  assign ram_wdata.hess      = in_item.hessian;

  // Column sums and the hand-off queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      tg_r         <= '0;
      th_r         <= '0;
      desc_valid_r <= 1'b0;
    end else begin
      if (desc_ack) begin
        desc_valid_r <= 1'b0;
      end
      if (accept) begin
        if (in_item.column_end | in_item.node_end) begin
          desc_r.count      <= count_nxt;
          desc_r.total_grad <= tg_nxt;
          desc_r.total_hess <= th_nxt;
          desc_r.feature    <= in_item.feature_id;
          desc_r.node_end   <= in_item.node_end;
          desc_valid_r      <= 1'b1;
          count_r           <= '0;
          tg_r              <= '0;
          th_r              <= '0;
        end else begin
          count_r <= count_nxt;
          tg_r    <= tg_nxt;
          th_r    <= th_nxt;
        end
      end
    end
  end

  assign desc_valid = desc_valid_r;
  assign desc       = desc_r;

endmodule

[hw/rtl/gbs_arith.sv]
// Shared multi-cycle unit for split scores g*g/(2*(h+lambda)) and weights -g*65536/(h+lambda).
// Serial shift-add squarer, used for scores only, followed by a restoring divider, one bit per cycle. Uses gbs_pkg.
module gbs_arith (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic                                is_weight,
  input  logic signed [gbs_pkg::SUM_W-1:0]    g,
  input  logic [gbs_pkg::SUM_W-1:0]           h,
  input  logic [gbs_pkg::LAMBDA_W-1:0]        lambda,
  output logic                                done,
  output logic [gbs_pkg::SQ_W-1:0]            score,
  output logic [gbs_pkg::WEIGHT_W-1:0]        weight
);

  localparam int SUM_W = gbs_pkg::SUM_W;
  localparam int SQ_W  = gbs_pkg::SQ_W;
  localparam int DEN_W = gbs_pkg::DEN_W;
  localparam int CW    = $clog2(SQ_W);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_MUL  = 3'b010,
    A_DIV  = 3'b100
  } arith_state_t;

  arith_state_t        state_r;
  logic [CW-1:0]       cnt_r;
  logic [SQ_W-1:0]     acc_r;
  logic [SQ_W-1:0]     a_r;
  logic [SUM_W-1:0]    b_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W-1:0]    rem_r;
  logic                pos_r;
  logic                done_r;

  logic [SUM_W:0]      d_sum;
  logic [SUM_W-1:0]    mag;
  logic [DEN_W:0]      r_sh;
  logic [DEN_W:0]      r_sub;
  logic                ge;

  assign d_sum = {1'b0, h} + {{(SUM_W+1-gbs_pkg::LAMBDA_W){1'b0}}, lambda};
  assign mag   = g[SUM_W-1] ? (~g + SUM_W'(1)) : g;

  // One restoring division step.
  assign r_sh  = {rem_r, acc_r[SQ_W-1]};
  assign ge    = r_sh >= {1'b0, den_r};
  assign r_sub = r_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        A_IDLE: begin
          if (go) begin
            pos_r <= ~g[SUM_W-1] & (g != '0);
            rem_r <= '0;
            if (d_sum == '0) begin
              // A zero denominator gives zero.
              acc_r  <= '0;
              done_r <= 1'b1;
            end else if (is_weight) begin
              acc_r   <= {{(SQ_W-SUM_W-16){1'b0}}, mag, 16'd0};
              den_r   <= DEN_W'(d_sum);
              cnt_r   <= CW'(SQ_W-1);
              state_r <= A_DIV;
            end else begin
              acc_r   <= '0;
              a_r     <= {{(SQ_W-SUM_W){1'b0}}, mag};
              b_r     <= mag;
              den_r   <= {d_sum, 1'b0};
              cnt_r   <= CW'(SUM_W-1);
              state_r <= A_MUL;
            end
          end
        end
        A_MUL: begin
          if (b_r[0]) begin
            acc_r <= acc_r + a_r;
          end
          a_r <= {a_r[SQ_W-2:0], 1'b0};
          b_r <= {1'b0, b_r[SUM_W-1:1]};
          if (cnt_r == '0) begin
            cnt_r   <= CW'(SQ_W-1);
            state_r <= A_DIV;
          end else begin
            cnt_r <= cnt_r - CW'(1);
          end
        end
        A_DIV: begin
          rem_r <= ge ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
          acc_r <= {acc_r[SQ_W-2:0], ge};
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            done_r  <= 1'b1;
            state_r <= A_IDLE;
          end
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  // Weight is the negated quotient, saturated to 32 bits.
  always_comb begin
    if (pos_r) begin
      if (acc_r > SQ_W'(32'h8000_0000)) begin
        weight = 32'h8000_0000;
      end else begin
        weight = 32'd0 - acc_r[31:0];
      end
    end else if (acc_r > SQ_W'(32'h7FFF_FFFF)) begin
      weight = 32'h7FFF_FFFF;
    end else begin
      weight = acc_r[31:0];
    end
  end

  assign score = acc_r;
  assign done  = done_r;

endmodule

[hw/rtl/gbs_back.sv]
// Scanner: walks a stored column, scores each eligible cut and keeps the best split.
// Emits the node result. Instantiates gbs_arith; uses gbs_pkg.
module gbs_back #(
  parameter int MAX_SAMPLES = gbs_pkg::DEF_MAX_SAMPLES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               desc_valid,
  input  gbs_pkg::col_desc_t                 desc,
  input  gbs_pkg::sample_t                   rd_data,
  input  logic [gbs_pkg::LAMBDA_W-1:0]       lambda,
  input  logic [gbs_pkg::MIN_SIDE_W-1:0]     min_side,
  output logic                               desc_ack,
  output logic [$clog2(MAX_SAMPLES)-1:0]     rd_addr,
  output logic                               busy,
  output logic                               out_valid,
  output gbs_pkg::result_t                   out_result
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int SUM_W = gbs_pkg::SUM_W;
  localparam int SQ_W  = gbs_pkg::SQ_W;
  localparam int CNT_W = gbs_pkg::CNT_W;

  typedef enum logic [11:0] {
    B_IDLE  = 12'b0000_0000_0001,
    B_PAR   = 12'b0000_0000_0010,
    B_FETCH = 12'b0000_0000_0100,
    B_EXAM  = 12'b0000_0000_1000,
    B_SCL   = 12'b0000_0001_0000,
    B_SCR   = 12'b0000_0010_0000,
    B_GAIN  = 12'b0000_0100_0000,
    B_CMP   = 12'b0000_1000_0000,
    B_WL    = 12'b0001_0000_0000,
    B_WR    = 12'b0010_0000_0000,
    B_NEXT  = 12'b0100_0000_0000,
    B_FIN   = 12'b1000_0000_0000
  } back_state_t;

  back_state_t               state_r;
  logic                      leaf_r;
  gbs_pkg::col_desc_t        desc_r;
  logic [CNT_W-1:0]          k_r;
  logic signed [SUM_W-1:0]   gl_r;
  logic [SUM_W-1:0]          hl_r;
  logic signed [SUM_W-1:0]   gr_r;
  logic [SUM_W-1:0]          hr_r;
  logic [31:0]               prev_r;
  gbs_pkg::sample_t          cur_r;
  logic [SQ_W-1:0]           parent_r;
  logic [SQ_W-1:0]           sl_r;
  logic [SQ_W-1:0]           sr_r;
  logic [63:0]               cand_r;
  logic [31:0]               wl_r;
  logic [63:0]               max_gain_r;
  logic [7:0]                best_feat_r;
  logic [31:0]               best_val_r;
  logic [31:0]               best_l_r;
  logic [31:0]               best_rt_r;
  logic                      found_r;
  logic                      out_valid_r;
  gbs_pkg::result_t          out_r;

  // Operand registers of the shared arithmetic unit.
  logic                      ar_go_r;
  logic                      ar_wt_r;
  logic signed [SUM_W-1:0]   ar_g_r;
  logic [SUM_W-1:0]          ar_h_r;
  logic                      ar_done;
  logic [SQ_W-1:0]           ar_score;
  logic [31:0]               ar_weight;

  logic [gbs_pkg::MIN_SIDE_W-1:0] need;
  logic                      eligible;
  logic [SQ_W+1:0]           gain_sum;
  logic                      gain_fits;
  logic [63:0]               gain_sat;
  logic                      split;

  gbs_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (ar_go_r),
    .is_weight (ar_wt_r),
    .g         (ar_g_r),
    .h         (ar_h_r),
    .lambda    (lambda),
    .done      (ar_done),
    .score     (ar_score),
    .weight    (ar_weight)
  );

  assign rd_addr  = k_r[AW-1:0];
  assign desc_ack = (state_r == B_IDLE) & desc_valid;
  assign busy     = (state_r != B_IDLE);

  // A cut needs distinct neighbor values and enough samples on both sides.
  assign need     = (min_side == '0) ? gbs_pkg::MIN_SIDE_W'(1) : min_side;
  assign eligible = (k_r != '0) && (prev_r != rd_data.value) &&
                    (k_r >= CNT_W'(need)) && ((desc_r.count - k_r) >= CNT_W'(need));

  // Gain is left plus right minus parent, saturated to 64 bits.
  assign gain_sum  = {2'b00, sl_r} + {2'b00, sr_r} - {2'b00, parent_r};
  assign gain_fits = (&gain_sum[SQ_W+1:63]) | ~(|gain_sum[SQ_W+1:63]);
  assign gain_sat  = gain_fits ? gain_sum[63:0] :
                     (gain_sum[SQ_W+1] ? gbs_pkg::GAIN_MIN : gbs_pkg::GAIN_MAX);

  assign split = found_r & ($signed(max_gain_r) > 64'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      ar_go_r     <= 1'b0;
      out_valid_r <= 1'b0;
      max_gain_r  <= gbs_pkg::GAIN_MIN;
      best_feat_r <= '0;
      best_val_r  <= '0;
      best_l_r    <= '0;
      best_rt_r   <= '0;
      found_r     <= 1'b0;
      leaf_r      <= 1'b0;
    end else begin
      ar_go_r     <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        // Take a column and start its parent score.
        B_IDLE: begin
          if (desc_valid) begin
            desc_r  <= desc;
            k_r     <= '0;
            gl_r    <= '0;
            hl_r    <= '0;
            ar_go_r <= 1'b1;
            ar_wt_r <= 1'b0;
            ar_g_r  <= desc.total_grad;
            ar_h_r  <= desc.total_hess;
            state_r <= B_PAR;
          end
        end
        B_PAR: begin
          if (ar_done) begin
            parent_r <= ar_score;
            state_r  <= (desc_r.count < CNT_W'(2)) ? B_FIN : B_FETCH;
          end
        end
        // Memory read of sample k is in flight.
        B_FETCH: state_r <= B_EXAM;
        B_EXAM: begin
          cur_r <= rd_data;
          gr_r  <= desc_r.total_grad - gl_r;
          hr_r  <= desc_r.total_hess - hl_r;
          if (eligible) begin
            ar_go_r <= 1'b1;
            ar_wt_r <= 1'b0;
            ar_g_r  <= gl_r;
            ar_h_r  <= hl_r;
            state_r <= B_SCL;
          end else begin
            state_r <= B_NEXT;
          end
        end
        B_SCL: begin
          if (ar_done) begin
            sl_r    <= ar_score;
            ar_go_r <= 1'b1;
            ar_wt_r <= 1'b0;
            ar_g_r  <= gr_r;
            ar_h_r  <= hr_r;
            state_r <= B_SCR;
          end
        end
        B_SCR: begin
          if (ar_done) begin
            sr_r    <= ar_score;
            state_r <= B_GAIN;
          end
        end
        B_GAIN: begin
          cand_r  <= gain_sat;
          state_r <= B_CMP;
        end
        // A strictly better cut needs its child weights.
        B_CMP: begin
          if ($signed(cand_r) > $signed(max_gain_r)) begin
            ar_go_r <= 1'b1;
            ar_wt_r <= 1'b1;
            ar_g_r  <= gl_r;
            ar_h_r  <= hl_r;
            state_r <= B_WL;
          end else begin
            state_r <= B_NEXT;
          end
        end
        B_WL: begin
          if (ar_done) begin
            wl_r    <= ar_weight;
            ar_go_r <= 1'b1;
            ar_wt_r <= 1'b1;
            ar_g_r  <= gr_r;
            ar_h_r  <= hr_r;
            state_r <= B_WR;
          end
        end
        B_WR: begin
          if (ar_done) begin
            max_gain_r  <= cand_r;
            best_feat_r <= desc_r.feature;
            best_val_r  <= prev_r;
            best_l_r    <= wl_r;
            best_rt_r   <= ar_weight;
            found_r     <= 1'b1;
            state_r     <= B_NEXT;
          end
        end
        // Fold sample k into the left side and move on.
        B_NEXT: begin
          gl_r   <= gl_r + {{(SUM_W-32){cur_r.grad[31]}}, cur_r.grad};
          hl_r   <= hl_r + {{(SUM_W-31){1'b0}}, cur_r.hess};
          prev_r <= cur_r.value;
          if (k_r == desc_r.count - CNT_W'(1)) begin
            state_r <= B_FIN;
          end else begin
            k_r     <= k_r + CNT_W'(1);
            state_r <= B_FETCH;
          end
        end
        // Column done; at node end emit the split or compute the leaf weight first.
        B_FIN: begin
          if (!desc_r.node_end) begin
            state_r <= B_IDLE;
          end else if (split || (leaf_r && ar_done)) begin
            out_r.split_found   <= split;
            out_r.split_feature <= split ? best_feat_r : 8'd0;
            out_r.best_value    <= split ? best_val_r : 32'd0;
            out_r.split_gain    <= split ? max_gain_r : 64'd0;
            out_r.left_weight   <= split ? best_l_r : 32'd0;
            out_r.right_weight  <= split ? best_rt_r : 32'd0;
            out_r.leaf_weight   <= split ? 32'd0 : ar_weight;
            out_valid_r         <= 1'b1;
            leaf_r              <= 1'b0;
            max_gain_r          <= gbs_pkg::GAIN_MIN;
            best_feat_r         <= '0;
            best_val_r          <= '0;
            best_l_r            <= '0;
            best_rt_r           <= '0;
            found_r             <= 1'b0;
            state_r             <= B_IDLE;
          end else if (!leaf_r) begin
            leaf_r  <= 1'b1;
            ar_go_r <= 1'b1;
            ar_wt_r <= 1'b1;
            ar_g_r  <= desc_r.total_grad;
            ar_h_r  <= desc_r.total_hess;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

[hw/rtl/gradient_boost_best_split_core.sv]
// Top level of the best-split search core: configuration registers, loader,
// sample memory and scanner. Uses gbs_pkg, gbs_front, gbs_ram and gbs_back.
//
// A sample beat is taken when start is high and busy is low; samples load at one
// per cycle while busy stays low. The beat that ends a column raises busy while
// the column is scanned. The scan first computes the parent score, then fetches
// and checks each stored sample, computes left and right scores for each cut that
// passes the side-count and equal-value checks, and computes both child weights
// whenever such a cut beats the best so far, and at node end a leaf weight
// when needed. One shared unit squares by shift and add and divides one
// quotient bit per cycle. The result is presented on out_result for a single
// cycle with out_valid high and cannot be held off by the receiver.
module gradient_boost_best_split_core #(
  parameter int MAX_SAMPLES = gbs_pkg::DEF_MAX_SAMPLES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  gbs_pkg::item_t             in_item,
  output logic                       out_valid,
  output gbs_pkg::result_t           out_result,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [gbs_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_SAMPLES);

  logic [gbs_pkg::LAMBDA_W-1:0]   lambda_r;
  logic [gbs_pkg::MIN_SIDE_W-1:0] min_side_r;

  logic                 back_busy;
  logic                 desc_ack;
  logic                 desc_valid;
  gbs_pkg::col_desc_t   desc;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  gbs_pkg::sample_t     ram_wdata;
  logic [AW-1:0]        ram_raddr;
  gbs_pkg::sample_t     ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r   <= gbs_pkg::LAMBDA_RESET;
      min_side_r <= gbs_pkg::MIN_SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbs_pkg::CFG_IDX_LAMBDA:   lambda_r   <= cfg_wdata[gbs_pkg::LAMBDA_W-1:0];
        gbs_pkg::CFG_IDX_MIN_SIDE: min_side_r <= cfg_wdata[gbs_pkg::MIN_SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  gbs_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .back_busy  (back_busy),
    .desc_ack   (desc_ack),
    .busy       (busy),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  gbs_ram #(
    .WIDTH ($bits(gbs_pkg::sample_t)),
    .DEPTH (MAX_SAMPLES)
  ) u_samples (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gbs_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (desc_valid),
    .desc       (desc),
    .rd_data    (ram_rdata),
    .lambda     (lambda_r),
    .min_side   (min_side_r),
    .desc_ack   (desc_ack),
    .rd_addr    (ram_raddr),
    .busy       (back_busy),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule
